FILE: rtl/ata_pio_command_issuer_unit_assert.svh
// ----------------------------------------------------------------------------
// ATA PIO command issuer assertion macros
// Concurrent check wrappers; they compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ATA_PIO_COMMAND_ISSUER_UNIT_ASSERT_SVH
`define ATA_PIO_COMMAND_ISSUER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define APCI_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("apci assertion failed");
// next-cycle implication
`define APCI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("apci assertion failed");
`else
`define APCI_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define APCI_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/apci_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ATA PIO command issuer package
// Shared types and task-file constants.
// ----------------------------------------------------------------------------
package apci_pkg;

	// configuration register indexes
	localparam logic [2:0] CFG_SIZE0 = 3'd0;
	localparam logic [2:0] CFG_SIZE1 = 3'd1;
	localparam logic [2:0] CFG_SIZE2 = 3'd2;
	localparam logic [2:0] CFG_SIZE3 = 3'd3;
	localparam logic [2:0] CFG_LBA28 = 3'd4;
	localparam logic [2:0] CFG_LOC   = 3'd5;
	localparam logic [2:0] CFG_IRQ   = 3'd6;

	localparam logic [7:0] LOC_RESET = 8'hE4;

	// division by 63 via reciprocal: q0 = (n * RECIP_63) >> RECIP_SHIFT
	// gives the quotient or one less
	localparam logic [31:0] RECIP_63    = 32'd2181570690;
	localparam int          RECIP_SHIFT = 37;
	localparam int          QEST_W      = 64 - RECIP_SHIFT;
	localparam logic [6:0]  CHS_SPT     = 7'd63;

	// task-file bytes
	localparam logic [7:0] DEVSEL_CHS    = 8'hA0;
	localparam logic [7:0] DEVSEL_LBA    = 8'hE0;
	localparam logic [7:0] CTL_HOB       = 8'h80;
	localparam logic [7:0] CMD_READ      = 8'h20;
	localparam logic [7:0] CMD_WRITE     = 8'h30;
	localparam logic [7:0] CMD_READ_EXT  = 8'h24;
	localparam logic [7:0] CMD_WRITE_EXT = 8'h34;

	// port offsets
	localparam logic [2:0] OFS_DEVCTL  = 3'd0;
	localparam logic [2:0] OFS_SECCNT  = 3'd2;
	localparam logic [2:0] OFS_LBA0    = 3'd3;
	localparam logic [2:0] OFS_LBA1    = 3'd4;
	localparam logic [2:0] OFS_LBA2    = 3'd5;
	localparam logic [2:0] OFS_DEVHEAD = 3'd6;
	localparam logic [2:0] OFS_CMD     = 3'd7;

	localparam logic BLK_CMD = 1'b0;
	localparam logic BLK_CTL = 1'b1;

	// emit sequence steps: LBA48 runs 0..17, others run 0 then 13..17
	localparam logic [4:0] STEP_FIRST    = 5'd0;
	localparam logic [4:0] STEP_LBA_TAIL = 5'd13;
	localparam logic [4:0] STEP_LAST     = 5'd17;

	typedef struct packed {
		logic [3:0][31:0] size;
		logic [3:0]       lba28_mask;
		logic [7:0]       location;
		logic             irq_disable;
	} cfg_t;

	// one prepared request, ready for emission
	typedef struct packed {
		logic       err;
		logic       lba48;
		logic       ch;
		logic [7:0] ctl;
		logic [7:0] devsel;
		logic [7:0] lba_hi;
		logic [7:0] cnt;
		logic [7:0] lba0;
		logic [7:0] lba1;
		logic [7:0] lba2;
		logic [7:0] cmd;
	} job_t;

	typedef struct packed {
		logic       write_valid;
		logic       channel;
		logic       port_block;
		logic [2:0] port_offset;
		logic [7:0] write_data;
		logic       error;
		logic       last;
	} res_t;

endpackage
`default_nettype wire

FILE: rtl/apci_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ATA PIO command issuer configuration registers
// Write-only register file: drive sizes, LBA28 mask, locations, nIEN.
// ----------------------------------------------------------------------------
module apci_cfg_regs
	import apci_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_wdata,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	// register writes; unknown index is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.size        <= '0;
			cfg_q.lba28_mask  <= '0;
			cfg_q.location    <= LOC_RESET;
			cfg_q.irq_disable <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SIZE0: cfg_q.size[0]      <= cfg_wdata;
				CFG_SIZE1: cfg_q.size[1]      <= cfg_wdata;
				CFG_SIZE2: cfg_q.size[2]      <= cfg_wdata;
				CFG_SIZE3: cfg_q.size[3]      <= cfg_wdata;
				CFG_LBA28: cfg_q.lba28_mask   <= cfg_wdata[3:0];
				CFG_LOC:   cfg_q.location     <= cfg_wdata[7:0];
				CFG_IRQ:   cfg_q.irq_disable  <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

FILE: rtl/apci_setup.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ATA PIO command issuer request setup
// Two-stage pipeline: input register, reciprocal multiply, then range check,
// mode choice and task-file byte formation.
// ----------------------------------------------------------------------------
module apci_setup
	import apci_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        in_action,
	input  wire logic [1:0]  in_drive,
	input  wire logic [31:0] in_lba,
	input  wire logic [7:0]  in_cnt,
	input  wire cfg_t        cfg,
	output logic             job_valid,
	input  wire logic        job_ready,
	output job_t             job
);

	logic              valid_s1, valid_s2;
	logic              action_s1, action_s2;
	logic [1:0]        drive_s1, drive_s2;
	logic [31:0]       lba_s1, lba_s2;
	logic [7:0]        cnt_s1, cnt_s2;
	logic [QEST_W-1:0] qest_s2;
	logic [63:0]       prod;
	logic              adv1, adv2;

	assign adv2     = !valid_s2 || job_ready;
	assign adv1     = !valid_s1 || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= in_valid;
			if (adv2) valid_s2 <= valid_s1;
		end
	end

	// quotient estimate for CHS
	assign prod = 64'(lba_s1) * 64'(RECIP_63);

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			action_s1 <= in_action;
			drive_s1  <= in_drive;
			lba_s1    <= in_lba;
			cnt_s1    <= in_cnt;
		end
		if (adv2 && valid_s1) begin
			action_s2 <= action_s1;
			drive_s2  <= drive_s1;
			lba_s2    <= lba_s1;
			cnt_s2    <= cnt_s1;
			qest_s2   <= prod[63:RECIP_SHIFT];
		end
	end

	// stage 2: correct quotient, range check, task-file bytes
	logic [31:0]       q63x;
	logic [6:0]        rem0;
	logic              fix;
	logic [QEST_W-1:0] quot;
	logic [5:0]        rem;
	logic [32:0]       end_blk;
	logic              lba48, lba28;
	logic [3:0]        head;
	logic              slave;

	assign q63x    = {qest_s2[QEST_W-7:0], 6'b0} - 32'(qest_s2);
	assign rem0    = 7'(lba_s2 - q63x);
	assign fix     = rem0 >= CHS_SPT;
	assign quot    = qest_s2 + QEST_W'(fix);
	assign rem     = fix ? 6'(rem0 - CHS_SPT) : rem0[5:0];
	assign end_blk = {1'b0, lba_s2} + 33'(cnt_s2);
	assign lba48   = |lba_s2[31:28];
	assign lba28   = cfg.lba28_mask[drive_s2];
	assign slave   = cfg.location[{drive_s2, 1'b0}];

	always_comb begin
		if (lba48)      head = 4'd0;
		else if (lba28) head = lba_s2[27:24];
		else            head = quot[3:0];
	end

	always_comb begin
		job.err    = end_blk > {1'b0, cfg.size[drive_s2]};
		job.lba48  = lba48;
		job.ch     = cfg.location[{drive_s2, 1'b1}];
		job.ctl    = {6'b0, cfg.irq_disable, 1'b0};
		job.devsel = ((lba48 || lba28) ? DEVSEL_LBA : DEVSEL_CHS)
		             | {3'b0, slave, head};
		job.lba_hi = lba_s2[31:24];
		job.cnt    = cnt_s2;
		if (lba48 || lba28) begin
			job.lba0 = lba_s2[7:0];
			job.lba1 = lba_s2[15:8];
			job.lba2 = lba_s2[23:16];
		end else begin
			// sector is 1-based; cylinder truncated to 16 bits
			job.lba0 = {2'b0, rem} + 8'd1;
			job.lba1 = quot[11:4];
			job.lba2 = quot[19:12];
		end
		if (lba48) job.cmd = action_s2 ? CMD_WRITE_EXT : CMD_READ_EXT;
		else       job.cmd = action_s2 ? CMD_WRITE : CMD_READ;
	end

	assign job_valid = valid_s2;

endmodule
`default_nettype wire

FILE: rtl/apci_emit.sv
`timescale 1ns / 1ps
`default_nettype none
`include "ata_pio_command_issuer_unit_assert.svh"
// ----------------------------------------------------------------------------
// ATA PIO command issuer write sequencer
// Holds one prepared request and steps through its port writes into an
// output register, one item per cycle while the receiver accepts them.
// ----------------------------------------------------------------------------
module apci_emit
	import apci_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic job_valid,
	output logic      job_ready,
	input  wire job_t job,
	output logic      out_valid,
	input  wire logic out_ready,
	output res_t      out
);

	job_t       job_q;
	logic       job_valid_q;
	logic [4:0] step_q;
	res_t       out_q;
	logic       out_valid_q;
	logic       out_load;
	logic       is_last;
	logic [4:0] step_next;
	res_t       res;

	assign out_load  = job_valid_q && (!out_valid_q || out_ready);
	assign is_last   = job_q.err || (step_q == STEP_LAST);
	assign job_ready = !job_valid_q || (out_load && is_last);
	assign step_next = (step_q == STEP_FIRST && !job_q.lba48) ? STEP_LBA_TAIL
	                                                          : step_q + 5'd1;

	// control: job slot, step counter, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			step_q      <= STEP_FIRST;
			out_valid_q <= 1'b0;
		end else begin
			if (job_ready) job_valid_q <= job_valid;
			if (out_load) step_q <= is_last ? STEP_FIRST : step_next;
			if (out_load)       out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (job_ready && job_valid) job_q <= job;
		if (out_load) out_q <= res;
	end

	// write selected by step
	always_comb begin
		res.write_valid = 1'b1;
		res.channel     = job_q.ch;
		res.port_block  = BLK_CMD;
		res.port_offset = OFS_DEVHEAD;
		res.write_data  = job_q.devsel;
		res.error       = 1'b0;
		res.last        = is_last;
		unique case (step_q)
			5'd0: begin
			end
			5'd1, 5'd4, 5'd7, 5'd10: begin
				res.port_block  = BLK_CTL;
				res.port_offset = OFS_DEVCTL;
				res.write_data  = CTL_HOB | job_q.ctl;
			end
			5'd3, 5'd6, 5'd9, 5'd12: begin
				res.port_block  = BLK_CTL;
				res.port_offset = OFS_DEVCTL;
				res.write_data  = job_q.ctl;
			end
			5'd2: begin
				res.port_offset = OFS_SECCNT;
				res.write_data  = 8'd0;
			end
			5'd5: begin
				res.port_offset = OFS_LBA0;
				res.write_data  = job_q.lba_hi;
			end
			5'd8: begin
				res.port_offset = OFS_LBA1;
				res.write_data  = 8'd0;
			end
			5'd11: begin
				res.port_offset = OFS_LBA2;
				res.write_data  = 8'd0;
			end
			5'd13: begin
				res.port_offset = OFS_SECCNT;
				res.write_data  = job_q.cnt;
			end
			5'd14: begin
				res.port_offset = OFS_LBA0;
				res.write_data  = job_q.lba0;
			end
			5'd15: begin
				res.port_offset = OFS_LBA1;
				res.write_data  = job_q.lba1;
			end
			5'd16: begin
				res.port_offset = OFS_LBA2;
				res.write_data  = job_q.lba2;
			end
			5'd17: begin
				res.port_offset = OFS_CMD;
				res.write_data  = job_q.cmd;
			end
			default: begin
			end
		endcase
		// out-of-range request: single error item
		if (job_q.err) begin
			res.write_valid = 1'b0;
			res.channel     = 1'b0;
			res.port_block  = 1'b0;
			res.port_offset = 3'd0;
			res.write_data  = 8'd0;
			res.error       = 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out       = out_q;

	`APCI_ASSERT_IMPLY(a_step_range, clk, arst_n, job_valid_q, step_q <= STEP_LAST)
	`APCI_ASSERT_IMPLY(a_err_single, clk, arst_n, out_load && job_q.err, step_q == STEP_FIRST)
	`APCI_ASSERT_IMPLY(a_short_skip, clk, arst_n, job_valid_q && !job_q.lba48, (step_q == STEP_FIRST) || (step_q >= STEP_LBA_TAIL))
	`APCI_ASSERT_NEXT(a_step_rewind, clk, arst_n, out_load && is_last, step_q == STEP_FIRST)

endmodule
`default_nettype wire

FILE: rtl/ata_pio_command_issuer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ATA PIO command issuer
// Turns a sector read/write request into the ordered task-file port writes.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request per item (drive, start block, sector count;
//   tuser is the action, 0 read / 1 write). m_axis carries the resulting port
//   writes, tlast on the final one of each request. An out-of-range request
//   gives one item with the error flag in tuser and no write.
//   The cfg port writes drive sizes, LBA28 mask, drive locations and nIEN;
//   write it only while no request is in flight.
//   Path: the first item of a request passes the input register, the multiply
//   register, the job register and the output register on its way to m_axis.
//   Throughput: one output item per cycle while m_axis_tready is high; a request
//   gives 18 port writes in LBA48 mode, 6 in LBA28/CHS mode and 1 item on error.
//   Up to two further requests wait in the setup stages while one is emitted.
//   A stalled receiver holds the output register; the sequencer and the
//   pipeline behind it stall, and s_axis_tready falls once all stages fill.
//   Reset clears all valid state and restores the configuration defaults.
// ----------------------------------------------------------------------------
module ata_pio_command_issuer_unit
	import apci_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [47:0] s_axis_tdata,  // drive_index, start_block, sector_count
	input  wire logic [0:0]  s_axis_tuser,  // action
	// port writes
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,  // channel, port_block, port_offset, write_data
	output logic [1:0]       m_axis_tuser,  // write_valid, error
	output logic             m_axis_tlast,
	// configuration
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_wdata
);

	cfg_t cfg;
	job_t job;
	logic job_valid, job_ready;
	res_t res;

	apci_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	apci_setup u_setup (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_action (s_axis_tuser[0]),
		.in_drive  (s_axis_tdata[1:0]),
		.in_lba    (s_axis_tdata[33:2]),
		.in_cnt    (s_axis_tdata[41:34]),
		.cfg       (cfg),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job)
	);

	apci_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out       (res)
	);

	// output packing
	assign m_axis_tdata = {3'b0, res.write_data, res.port_offset, res.port_block, res.channel};
	assign m_axis_tuser = {res.error, res.write_valid};
	assign m_axis_tlast = res.last;

endmodule
`default_nettype wire

FILE: tb/sv/ata_pio_command_issuer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ATA PIO command issuer testbench
// Sends read/write requests over the request stream and checks every
// task-file port write (and every range error) against a local predictor of
// the issuer. Covers drive sizes, addressing modes, channel/slave mapping,
// nIEN, random idling on both sides and a long output stall.
// ----------------------------------------------------------------------------
module ata_pio_command_issuer_unit_tb;
	import apci_pkg::*;

	localparam logic [31:0] LBA48_BASE   = 32'h1000_0000;
	localparam int unsigned HEAD_SPAN    = 16 * 63;        // sectors per cylinder
	localparam int          STALL_CYCLES = 400;
	localparam int          MAX_REPORTS  = 10;

	typedef enum logic [1:0] {MODE_CHS, MODE_LBA28, MODE_LBA48} addr_mode_e;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;
	logic [0:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_wdata;

	// predictor copy of the register file
	cfg_t shadow_cfg;
	res_t pending_port_writes [$];

	int send_idle_pct;
	int recv_idle_pct;
	int mismatches;
	int stall_requests;
	int stall_served;
	int hold_left;
	res_t seen_write;
	res_t want_write;

	ata_pio_command_issuer_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// queue one expected port write
	function automatic void add_write(input logic ch, input logic blk, input logic [2:0] ofs,
			input logic [7:0] data, input logic is_last);
		res_t w;
		w.write_valid = 1'b1;
		w.channel     = ch;
		w.port_block  = blk;
		w.port_offset = ofs;
		w.write_data  = data;
		w.error       = 1'b0;
		w.last        = is_last;
		pending_port_writes.push_back(w);
	endfunction

	// expected port writes for one request
	function automatic void predict_port_writes(input logic act, input logic [1:0] drv,
			input logic [31:0] lba, input logic [7:0] cnt);
		logic [32:0] end_blk;
		logic        ch;
		logic        slave;
		logic [7:0]  ctl;
		logic [7:0]  devsel;
		logic [7:0]  cmd;
		logic [7:0]  tf [8];
		logic [31:0] rem;
		logic [31:0] base;
		logic [31:0] cyl;
		logic [3:0]  head;
		addr_mode_e  mode;
		res_t        fault;
		end_blk = {1'b0, lba} + 33'(cnt);
		// out of range: single error item, nothing written
		if (end_blk > {1'b0, shadow_cfg.size[drv]}) begin
			fault = '0;
			fault.error = 1'b1;
			fault.last = 1'b1;
			pending_port_writes.push_back(fault);
			return;
		end
		ch = shadow_cfg.location[{drv, 1'b1}];
		slave = shadow_cfg.location[{drv, 1'b0}];
		ctl = {6'b0, shadow_cfg.irq_disable, 1'b0};
		foreach (tf[i]) tf[i] = 8'h00;
		tf[4] = cnt;
		if (lba >= LBA48_BASE) begin
			mode = MODE_LBA48;
			head = 4'h0;
			tf[1] = lba[31:24];
			tf[5] = lba[7:0];
			tf[6] = lba[15:8];
			tf[7] = lba[23:16];
		end else if (shadow_cfg.lba28_mask[drv]) begin
			mode = MODE_LBA28;
			head = lba[27:24];
			tf[5] = lba[7:0];
			tf[6] = lba[15:8];
			tf[7] = lba[23:16];
		end else begin
			// CHS geometry, cylinder keeps its low 16 bits
			mode = MODE_CHS;
			rem = lba % CHS_SPT;
			base = lba - rem;
			cyl = base / HEAD_SPAN;
			head = 4'((base % HEAD_SPAN) / CHS_SPT);
			tf[5] = 8'(rem + 1);
			tf[6] = cyl[7:0];
			tf[7] = cyl[15:8];
		end
		devsel = ((mode == MODE_CHS) ? DEVSEL_CHS : DEVSEL_LBA) | {3'b0, slave, head};
		if (mode == MODE_LBA48)
			cmd = act ? CMD_WRITE_EXT : CMD_READ_EXT;
		else
			cmd = act ? CMD_WRITE : CMD_READ;
		add_write(ch, BLK_CMD, OFS_DEVHEAD, devsel, 1'b0);
		// high-order bytes, each wrapped by HOB set / HOB clear
		if (mode == MODE_LBA48) begin
			for (int i = 0; i < 4; i++) begin
				add_write(ch, BLK_CTL, OFS_DEVCTL, CTL_HOB | ctl, 1'b0);
				add_write(ch, BLK_CMD, 3'(OFS_SECCNT + i), tf[i], 1'b0);
				add_write(ch, BLK_CTL, OFS_DEVCTL, ctl, 1'b0);
			end
		end
		for (int i = 0; i < 4; i++)
			add_write(ch, BLK_CMD, 3'(OFS_SECCNT + i), tf[4 + i], 1'b0);
		add_write(ch, BLK_CMD, OFS_CMD, cmd, 1'b1);
	endfunction

	// offer one request item, wait for acceptance, then predict
	task automatic send_request(input logic act, input logic [1:0] drv,
			input logic [31:0] lba, input logic [7:0] cnt);
		int gap;
		gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(6, 1) : 0;
		repeat (gap) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= 48'({$urandom, $urandom});
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'b0, cnt, lba, drv};
		s_axis_tuser <= act;
		do @(posedge clk); while (!s_axis_tready);
		predict_port_writes(act, drv, lba, cnt);
	endtask

	// random request, mostly in range for the addressed drive
	task automatic send_random_request();
		logic [1:0]  drv;
		logic        act;
		logic [7:0]  cnt;
		logic [31:0] lba;
		logic [31:0] size;
		logic [31:0] room;
		int          pick;
		drv = 2'($urandom_range(3));
		act = 1'($urandom_range(1));
		cnt = 8'($urandom_range(255));
		size = shadow_cfg.size[drv];
		pick = $urandom_range(99);
		if (pick < 12) begin
			lba = $urandom;
		end else if (pick < 22) begin
			// just past the end of the drive
			lba = size - $urandom_range(cnt) + 1;
		end else begin
			if (size < 32'(cnt))
				cnt = size[7:0];
			room = size - 32'(cnt);
			if (pick < 55)
				lba = $urandom_range(room);
			else if (pick < 80)
				lba = $urandom_range((room < 32'h0FFF_FFFF) ? room : 32'h0FFF_FFFF);
			else if (pick < 90)
				lba = room - $urandom_range((room < 32'd15) ? room : 32'd15);
			else if (room >= LBA48_BASE + 32'h100)
				lba = LBA48_BASE - 32'h80 + $urandom_range(255);
			else
				lba = $urandom_range(room);
		end
		send_request(act, drv, lba, cnt);
	endtask

	task automatic wait_port_writes_drained();
		while (pending_port_writes.size() != 0)
			@(posedge clk);
	endtask

	// write every register, plus the unmapped index, back to back
	task automatic load_config(input logic [31:0] s0, input logic [31:0] s1,
			input logic [31:0] s2, input logic [31:0] s3, input logic [3:0] mask,
			input logic [7:0] loc, input logic irq);
		logic [31:0] vals [8];
		vals = '{s0, s1, s2, s3, {28'b0, mask}, {24'b0, loc}, {31'b0, irq}, $urandom};
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= 3'(i);
			cfg_wdata <= vals[i];
			case (3'(i))
				CFG_SIZE0, CFG_SIZE1, CFG_SIZE2, CFG_SIZE3: shadow_cfg.size[i] = vals[i];
				CFG_LBA28: shadow_cfg.lba28_mask = vals[i][3:0];
				CFG_LOC:   shadow_cfg.location = vals[i][7:0];
				CFG_IRQ:   shadow_cfg.irq_disable = vals[i][0];
				default:   ;
			endcase
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// defaults after reset: zero sizes, location E4, CHS everywhere
	task automatic test_reset_defaults();
		send_request(1'b0, 2'd0, 32'd0, 8'd0);
		send_request(1'b1, 2'd1, 32'd0, 8'd0);
		send_request(1'b0, 2'd2, 32'd0, 8'd0);
		send_request(1'b1, 2'd3, 32'd0, 8'd0);
		send_request(1'b0, 2'd2, 32'd0, 8'd1);
		s_axis_tvalid <= 1'b0;
		wait_port_writes_drained();
	endtask

	// range edges, mode boundaries, CHS geometry corners
	task automatic test_range_and_modes();
		load_config(32'hFFFF_FFFF, LBA48_BASE, 32'd5000, 32'd0, 4'b0010, 8'h9C, 1'b1);
		send_request(1'b1, 2'd0, 32'h0FFF_FFFF, 8'd255);   // largest CHS, cylinder wraps
		send_request(1'b0, 2'd0, LBA48_BASE, 8'd1);        // first LBA48 block
		send_request(1'b1, 2'd0, 32'hFFFF_FF00, 8'd255);   // ends exactly at size
		send_request(1'b0, 2'd0, 32'hFFFF_FFFF, 8'd0);
		send_request(1'b0, 2'd0, 32'hFFFF_FFFF, 8'd1);     // sum needs 33 bits
		send_request(1'b1, 2'd0, 32'hFFFF_FFFF, 8'd255);
		send_request(1'b1, 2'd0, 32'h0ABC_DEF1, 8'h5A);
		send_request(1'b0, 2'd1, 32'h0FFF_FFFF, 8'd1);     // LBA28, head nibble F
		send_request(1'b1, 2'd1, 32'h0FFF_FFFF, 8'd2);     // one past the end
		send_request(1'b1, 2'd1, LBA48_BASE, 8'd0);        // start equals size
		send_request(1'b0, 2'd1, LBA48_BASE + 1, 8'd0);    // start beyond size
		send_request(1'b0, 2'd2, 32'd62, 8'd0);            // last sector of a track
		send_request(1'b1, 2'd2, 32'd63, 8'd0);
		send_request(1'b0, 2'd2, 32'd1007, 8'd0);          // last head of cylinder 0
		send_request(1'b1, 2'd2, 32'd1008, 8'd0);
		send_request(1'b0, 2'd2, 32'd4745, 8'd255);
		send_request(1'b1, 2'd2, 32'd5000, 8'd0);
		send_request(1'b0, 2'd3, 32'd0, 8'd0);             // empty drive, empty request
		send_request(1'b1, 2'd3, 32'd0, 8'd1);
		s_axis_tvalid <= 1'b0;
		wait_port_writes_drained();
	endtask

	task automatic test_random_traffic(input int snd_pct, input int rcv_pct, input int n_items);
		send_idle_pct = snd_pct;
		recv_idle_pct = rcv_pct;
		repeat (n_items)
			send_random_request();
		s_axis_tvalid <= 1'b0;
		wait_port_writes_drained();
	endtask

	// receiver holds off while requests keep coming, pipeline fills up
	task automatic test_backpressure();
		load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			4'($urandom_range(15)), 8'($urandom_range(255)), 1'($urandom_range(1)));
		send_idle_pct = 0;
		recv_idle_pct = 0;
		stall_requests++;
		repeat (15)
			send_random_request();
		s_axis_tvalid <= 1'b0;
		wait_port_writes_drained();
	endtask

	// output side: ready pattern and result checking
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen_write.write_valid = m_axis_tuser[0];
			seen_write.error       = m_axis_tuser[1];
			seen_write.channel     = m_axis_tdata[0];
			seen_write.port_block  = m_axis_tdata[1];
			seen_write.port_offset = m_axis_tdata[4:2];
			seen_write.write_data  = m_axis_tdata[12:5];
			seen_write.last        = m_axis_tlast;
			if (pending_port_writes.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected item wv=%0d ch=%0d blk=%0d ofs=%0d data=%02h err=%0d last=%0d",
						$realtime, seen_write.write_valid, seen_write.channel,
						seen_write.port_block, seen_write.port_offset, seen_write.write_data,
						seen_write.error, seen_write.last);
			end else begin
				want_write = pending_port_writes.pop_front();
				if (seen_write !== want_write) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("%0t: mismatch expected wv=%0d ch=%0d blk=%0d ofs=%0d data=%02h err=%0d last=%0d",
							$realtime, want_write.write_valid, want_write.channel,
							want_write.port_block, want_write.port_offset, want_write.write_data,
							want_write.error, want_write.last);
						$display("%0t:          actual   wv=%0d ch=%0d blk=%0d ofs=%0d data=%02h err=%0d last=%0d",
							$realtime, seen_write.write_valid, seen_write.channel,
							seen_write.port_block, seen_write.port_offset, seen_write.write_data,
							seen_write.error, seen_write.last);
					end
				end
			end
		end
		// long hold-off when requested, random idling otherwise
		if (stall_requests != stall_served) begin
			stall_served = stall_requests;
			hold_left = STALL_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// main sequence
	initial begin
		clk = 1'b0;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		mismatches = 0;
		stall_requests = 0;
		stall_served = 0;
		hold_left = 0;
		shadow_cfg.size = '0;
		shadow_cfg.lba28_mask = '0;
		shadow_cfg.location = LOC_RESET;
		shadow_cfg.irq_disable = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_range_and_modes();
		load_config(32'hFFFF_FFFF, $urandom, 32'hFFFF_FFFF, 32'h00FF_FFFF, 4'hF, 8'hFF, 1'b0);
		test_random_traffic(20, 46, 115);
		load_config($urandom, 32'hFFFF_FFFF, 32'h0FFF_0000, 32'hFFFF_FFFF, 4'h0, 8'h00, 1'b1);
		test_random_traffic(46, 20, 115);
		load_config($urandom, $urandom, 32'hFFFF_FFFF, $urandom_range(300),
			4'($urandom_range(15)), 8'($urandom_range(255)), 1'($urandom_range(1)));
		test_random_traffic(0, 0, 105);
		test_backpressure();

		repeat (20) @(posedge clk);
		if (pending_port_writes.size() != 0)
			$display("%0d expected items never arrived", pending_port_writes.size());
		if (mismatches == 0 && pending_port_writes.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// watchdog
	initial begin
		#3_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/apci_pkg.sv
rtl/apci_cfg_regs.sv
rtl/apci_setup.sv
rtl/apci_emit.sv
rtl/ata_pio_command_issuer_unit.sv
tb/sv/ata_pio_command_issuer_unit_tb.sv
